@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL files; the deframer core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/spd_pkg.sv @@
package spd_pkg;

    localparam int BAD_COUNT_WIDTH = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] START_CODE_RESET    = 8'd35;
    localparam logic [7:0] ESCAPE_CODE_RESET   = 8'd63;
    localparam logic [7:0] UNESCAPE_MASK_RESET = 8'h20;

    typedef enum logic [1:0] {
        REG_START_CODE    = 2'd0,
        REG_ESCAPE_CODE   = 2'd1,
        REG_UNESCAPE_MASK = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } op_code_t;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_ID,
        PH_SIZE_LO,
        PH_SIZE_HI,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef struct packed {
        op_code_t   code;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  packet_id;
        logic [15:0] packet_size;
        logic [15:0] bad_count;
        logic        last;
    } result_t;

    function automatic logic [15:0] sat16(input logic [BAD_COUNT_WIDTH-1:0] value);
        logic [BAD_COUNT_WIDTH+15:0] wide;
        wide = (BAD_COUNT_WIDTH + 16)'(value);
        if (wide > (BAD_COUNT_WIDTH + 16)'(17'h0FFFF))
        begin
            return 16'hFFFF;
        end
        return wide[15:0];
    endfunction

endpackage

@@ rtl/core/stuffed_packet_deframer_core.sv @@
// Channel    Direction  Contents
// s_axis     in         tdata: raw link byte
// m_axis     out        tuser: kind; tdata: payload byte, id, size, bad count; tlast
// cfg        in         write enable, register index, 8-bit value
//
// Each part handles one word per cycle, the input while the queue is not full and the
// back end while its output register is empty or being taken. Accepted words are
// queued; a popped word's result, if it has one, lands in the output register. While a
// result waits there, the input keeps taking words until four queued words fill the
// queue; escape bytes take no queue entry. Then s_axis_tready stays low until the
// result is taken. Reset clears the queue, the framer state and the bad-packet
// counter, and restores the register defaults.
`include "assert_macros.svh"

module stuffed_packet_deframer_core
    import spd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] data_byte, [15:8] packet_id,
                                        // [31:16] packet_size, [47:32] bad_count
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    logic    accept;
    logic    push;
    op_t     push_op;
    logic    q_full;
    logic    q_nonempty;
    logic    pop;
    op_t     head_op;
    result_t result;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    spd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_axis_tdata),
        .push      (push),
        .push_op   (push_op)
    );

    spd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .full     (q_full),
        .pop      (pop),
        .nonempty (q_nonempty),
        .head_op  (head_op)
    );

    spd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (q_nonempty),
        .op         (head_op),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {result.bad_count, result.packet_size, result.packet_id,
                           result.data_byte};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

    `ASSERT_SAME(a_last_on_verdict, clk, rst_n, m_axis_tvalid,
        m_axis_tlast == (m_axis_tuser != KIND_PAYLOAD), "tlast does not match verdict")
    `ASSERT_SAME(a_verdict_no_data, clk, rst_n, m_axis_tvalid && m_axis_tlast,
        m_axis_tdata[7:0] == 8'd0, "verdict word carries payload data")
    `ASSERT_SAME(a_bad_counted, clk, rst_n, m_axis_tvalid && (m_axis_tuser == KIND_BAD),
        m_axis_tdata[47:32] != 16'd0, "bad verdict with zero bad count")

endmodule

@@ rtl/core/spd_front.sv @@
module spd_front
    import spd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output op_t        push_op
);

    logic [7:0] start_code_reg;
    logic [7:0] escape_code_reg;
    logic [7:0] unescape_mask_reg;
    logic       escape_reg;
    logic       escape_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg    <= START_CODE_RESET;
            escape_code_reg   <= ESCAPE_CODE_RESET;
            unescape_mask_reg <= UNESCAPE_MASK_RESET;
            escape_reg        <= 1'b0;
        end
        else
        begin
            escape_reg <= escape_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_START_CODE:    start_code_reg    <= cfg_wdata;
                    REG_ESCAPE_CODE:   escape_code_reg   <= cfg_wdata;
                    REG_UNESCAPE_MASK: unescape_mask_reg <= cfg_wdata;
                    default:           ;
                endcase
            end
        end
    end

    // The raw byte is compared before unescaping, so a start code always wins.
    always_comb
    begin
        escape_next  = escape_reg;
        push         = 1'b0;
        push_op.code = OP_DATA;
        push_op.data = in_byte;
        if (accept)
        begin
            if (in_byte == start_code_reg)
            begin
                push         = 1'b1;
                push_op.code = OP_START;
                escape_next  = 1'b0;
            end
            else if (in_byte == escape_code_reg)
            begin
                escape_next = 1'b1;
            end
            else
            begin
                push         = 1'b1;
                push_op.data = escape_reg ? (in_byte ^ unescape_mask_reg) : in_byte;
                escape_next  = 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/spd_fifo.sv @@
module spd_fifo
    import spd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output op_t  head_op
);

    op_t                    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign head_op  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QUEUE_CNT_W'(1);
                2'b01:   count_reg <= count_reg - QUEUE_CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/spd_back.sv @@
module spd_back
    import spd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_valid,
    input  op_t     op,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    phase_t                     phase_reg,   phase_next;
    logic [7:0]                 sum_reg,     sum_next;
    logic [7:0]                 id_reg,      id_next;
    logic [15:0]                size_reg,    size_next;
    logic [15:0]                left_reg,    left_next;
    logic [BAD_COUNT_WIDTH-1:0] bad_reg,     bad_next;
    logic                       valid_reg,   valid_next;
    result_t                    result_reg,  result_next;
    logic                       emit;
    logic [7:0]                 sum_add;
    logic [15:0]                left_dec;

    assign pop        = op_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign sum_add    = sum_reg + op.data;
    assign left_dec   = left_reg - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            sum_reg   <= '0;
            id_reg    <= '0;
            size_reg  <= '0;
            left_reg  <= '0;
            bad_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
            bad_reg   <= bad_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        id_next     = id_reg;
        size_next   = size_reg;
        left_next   = left_reg;
        bad_next    = bad_reg;
        emit        = 1'b0;
        result_next = result_reg;
        result_next.kind      = KIND_PAYLOAD;
        result_next.data_byte = 8'd0;
        result_next.last      = 1'b0;

        if (pop)
        begin
            if (op.code == OP_START)
            begin
                phase_next = PH_ID;
                sum_next   = '0;
                id_next    = '0;
                size_next  = '0;
                left_next  = '0;
            end
            else
            begin
                sum_next = sum_add;
                case (phase_reg)
                    PH_WAIT:
                    begin
                    end
                    PH_ID:
                    begin
                        id_next    = op.data;
                        phase_next = PH_SIZE_LO;
                    end
                    PH_SIZE_LO:
                    begin
                        size_next  = {8'd0, op.data};
                        phase_next = PH_SIZE_HI;
                    end
                    PH_SIZE_HI:
                    begin
                        size_next  = {op.data, size_reg[7:0]};
                        left_next  = {op.data, size_reg[7:0]};
                        phase_next = ({op.data, size_reg[7:0]} == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        left_next = left_dec;
                        if (left_dec == 16'd0)
                        begin
                            phase_next = PH_CHECK;
                        end
                        emit                  = 1'b1;
                        result_next.data_byte = op.data;
                    end
                    PH_CHECK:
                    begin
                        phase_next       = PH_WAIT;
                        emit             = 1'b1;
                        result_next.last = 1'b1;
                        if (sum_add == 8'd0)
                        begin
                            result_next.kind = KIND_GOOD;
                        end
                        else
                        begin
                            result_next.kind = KIND_BAD;
                            if (bad_reg != '1)
                            begin
                                bad_next = bad_reg + BAD_COUNT_WIDTH'(1);
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end

        result_next.packet_id   = id_next;
        result_next.packet_size = size_next;
        result_next.bad_count   = sat16(bad_next);

        if (!emit)
        begin
            result_next = result_reg;
        end

        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

endmodule
